// ===== design/ip6p_pkg.sv =====
// ----------------------------------------------------------------------------
// ip6p_pkg
// shared constants, types and helpers for the ipv6 text parser
// ----------------------------------------------------------------------------
package ip6p_pkg;

  localparam int GROUP_COUNT = 8;
  localparam int MAX_DIGITS  = 4;
  localparam int GROUP_W     = 16;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [3:0] GROUP_CNT4 = 4'd8;
  localparam logic [3:0] GAP_MAX4   = 4'd7;
  localparam logic [2:0] MAX_DIG3   = 3'd4;

  typedef logic [GROUP_W-1:0] group_t;

  // push control broadcast to the row of group cells
  typedef struct packed {
    logic   push;   // a finished group enters the row this cycle
    logic   gap;    // a "::" has been seen (post-gap insertion mode)
    logic   clear;  // address done, return cells to reset state
    group_t data;   // group value being pushed
  } cell_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ascii hex digit decode
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== design/ip6p_in_if.sv =====
// ----------------------------------------------------------------------------
// ip6p_in_if
// character channel: one ascii character per transfer with a last mark
// ----------------------------------------------------------------------------
interface ip6p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== design/ip6p_out_if.sv =====
// ----------------------------------------------------------------------------
// ip6p_out_if
// result channel: parsed 128-bit address as two halves plus error flag
// ----------------------------------------------------------------------------
interface ip6p_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic        malformed;

  modport source (output valid, output address_high, output address_low,
                  output malformed, input ready);
  modport sink   (input valid, input address_high, input address_low,
                  input malformed, output ready);
endinterface

// ===== design/ipv6_text_to_bits_parser.sv =====
// ----------------------------------------------------------------------------
// ipv6_text_to_bits_parser
// parses ipv6 address text, one character per transfer, into 128 bits
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid / ready | character[7:0], last_char
//   out_ch  | out | valid / ready | address_high[63:0], address_low[63:0], malformed
//
// one character is taken per cycle unless in_ch is stalled; the address leaves in
// the cycle after its last character, through a single output register.
// groups are held in a row of eight cells; the gap is expanded in place as
// groups arrive, so the address is complete when its last character is taken.
// synchronous active-low reset clears the parser and the cell row.
// in_ch stalls only while a finished address waits and out_ch is not ready.
// ----------------------------------------------------------------------------
module ipv6_text_to_bits_parser (
  input  logic       clk,
  input  logic       rst_n,
  ip6p_in_if.sink    in_ch,
  ip6p_out_if.source out_ch
);
  import ip6p_pkg::*;

  cell_ctl_t ctl;
  logic      fire, fin, bad;
  logic      in_ready;
  logic [GROUP_COUNT:0] used;
  group_t    grp   [GROUP_COUNT];
  group_t    upd   [GROUP_COUNT];
  group_t    dnext [GROUP_COUNT];

  logic        out_valid_r;
  logic [63:0] hi_r, lo_r;
  logic        bad_r;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;

  ip6p_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .character (in_ch.character),
    .last_char (in_ch.last_char),
    .ctl       (ctl),
    .fin       (fin),
    .bad       (bad)
  );

  // row of group cells
  assign used[0] = 1'b1;
  genvar i;
  generate
    for (i = 0; i < GROUP_COUNT; i++) begin : g_cell
      if (i == GROUP_COUNT - 1) begin : g_end
        assign dnext[i] = ctl.data;
      end else begin : g_mid
        assign dnext[i] = grp[i+1];
      end
      ip6p_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .used_in  (used[i]),
        .data_in  (dnext[i]),
        .used_out (used[i+1]),
        .grp_out  (grp[i]),
        .grp_upd  (upd[i])
      );
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      hi_r  <= bad ? 64'd0 : {upd[0], upd[1], upd[2], upd[3]};
      lo_r  <= bad ? 64'd0 : {upd[4], upd[5], upd[6], upd[7]};
      bad_r <= bad;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.address_high = hi_r;
  assign out_ch.address_low  = lo_r;
  assign out_ch.malformed    = bad_r;

  // checks
  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (hi_r == 64'd0 && lo_r == 64'd0))
    else $error("malformed result carries address bits");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !fin)
    else $error("result produced while output slot full");
  a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (used[GROUP_COUNT:1] & ~used[GROUP_COUNT-1:0]) == '0)
    else $error("cell fill pointer broken");

endmodule

// ===== design/ip6p_cell.sv =====
// ----------------------------------------------------------------------------
// ip6p_cell
// one group slot of the address row; fills left to right before the gap,
// shifts left from the right end after the gap
// ----------------------------------------------------------------------------
module ip6p_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ip6p_pkg::cell_ctl_t ctl,
  input  logic               used_in,   // left neighbor already holds a pre-gap group
  input  ip6p_pkg::group_t   data_in,   // right neighbor group, or new group at the end
  output logic               used_out,
  output ip6p_pkg::group_t   grp_out,   // registered group
  output ip6p_pkg::group_t   grp_upd    // group after this cycle's push
);
  import ip6p_pkg::*;

  logic   used_r, used_nxt;
  group_t grp_r, grp_nxt;

  // push handling
  always_comb begin
    grp_upd  = grp_r;
    used_nxt = used_r;
    if (ctl.push) begin
      if (!ctl.gap) begin
        if (used_in && !used_r) begin
          grp_upd  = ctl.data;
          used_nxt = 1'b1;
        end
      end else if (!used_r) begin
        grp_upd = data_in;
      end
    end
    grp_nxt = grp_upd;
    if (ctl.clear) begin
      grp_nxt  = '0;
      used_nxt = 1'b0;
    end
  end

  // cell state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      grp_r  <= '0;
    end else begin
      used_r <= used_nxt;
      grp_r  <= grp_nxt;
    end
  end

  assign used_out = used_r;
  assign grp_out  = grp_r;

endmodule

// ===== design/ip6p_ctrl.sv =====
// ----------------------------------------------------------------------------
// ip6p_ctrl
// character decode, group assembly, gap tracking and final validity check
// ----------------------------------------------------------------------------
module ip6p_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          character,
  input  logic                last_char,
  output ip6p_pkg::cell_ctl_t ctl,
  output logic                fin,
  output logic                bad
);
  import ip6p_pkg::*;

  logic [3:0] gs_r, gs_nxt, gs_fin;
  group_t     cur_r, cur_nxt;
  logic [2:0] dig_r, dig_nxt;
  logic [3:0] gpos_r, gpos_nxt;
  logic       gap_r, gap_nxt;
  logic       prev_r, prev_nxt;
  logic       err_r, err_nxt;
  logic       push_take, push_fin;
  hex_t       hx;

  assign hx = hex_decode(character);

  // per-character update and end-of-address check
  always_comb begin
    gs_nxt    = gs_r;
    cur_nxt   = cur_r;
    dig_nxt   = dig_r;
    gpos_nxt  = gpos_r;
    gap_nxt   = gap_r;
    prev_nxt  = prev_r;
    err_nxt   = err_r;
    push_take = 1'b0;
    push_fin  = 1'b0;
    if (!err_r) begin
      if (character == COLON_CHAR) begin
        if (prev_r) begin
          if (gap_r) begin
            err_nxt = 1'b1;
          end else begin
            gap_nxt  = 1'b1;
            gpos_nxt = gs_r;
            prev_nxt = 1'b1;
          end
        end else if (dig_r != 3'd0) begin
          if (gs_r >= GROUP_CNT4) err_nxt = 1'b1;
          else push_take = 1'b1;
          prev_nxt = 1'b1;
        end else if (gs_r != 4'd0 || gap_r) begin
          err_nxt = 1'b1;
        end else begin
          prev_nxt = 1'b1;
        end
      end else if (!hx.ok) begin
        err_nxt = 1'b1;
      end else if (prev_r && gs_r == 4'd0 && !gap_r) begin
        err_nxt = 1'b1;
      end else if (dig_r >= MAX_DIG3) begin
        err_nxt = 1'b1;
      end else begin
        cur_nxt  = {cur_r[GROUP_W-5:0], hx.val};
        dig_nxt  = dig_r + 3'd1;
        prev_nxt = 1'b0;
      end
    end
    if (push_take) begin
      gs_nxt  = gs_r + 4'd1;
      cur_nxt = '0;
      dig_nxt = 3'd0;
    end

    // finish: flush the open group and check the group count
    bad    = err_nxt;
    gs_fin = gs_nxt;
    if (!bad) begin
      if (dig_nxt != 3'd0) begin
        if (gs_nxt >= GROUP_CNT4) begin
          bad = 1'b1;
        end else begin
          push_fin = 1'b1;
          gs_fin   = gs_nxt + 4'd1;
        end
      end else if (!(prev_nxt && gap_nxt && gpos_nxt == gs_nxt)) begin
        bad = 1'b1;
      end
    end
    if (!bad) begin
      if (gap_nxt ? (gs_fin > GAP_MAX4) : (gs_fin != GROUP_CNT4)) bad = 1'b1;
    end
  end

  // cell row control
  assign fin       = fire && last_char;
  assign ctl.push  = fire && (push_take || (last_char && push_fin));
  assign ctl.gap   = gap_nxt;
  assign ctl.clear = fin;
  assign ctl.data  = push_take ? cur_r : cur_nxt;

  // parser state, cleared after each address
  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      gs_r   <= '0;
      cur_r  <= '0;
      dig_r  <= '0;
      gpos_r <= '0;
      gap_r  <= 1'b0;
      prev_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (fire) begin
      gs_r   <= gs_nxt;
      cur_r  <= cur_nxt;
      dig_r  <= dig_nxt;
      gpos_r <= gpos_nxt;
      gap_r  <= gap_nxt;
      prev_r <= prev_nxt;
      err_r  <= err_nxt;
    end
  end

  // checks
  a_gs_range: assert property (@(posedge clk) disable iff (!rst_n)
    gs_r <= GROUP_CNT4) else $error("group count above eight");
  a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
    dig_r <= MAX_DIG3) else $error("digit count above four");
  a_gap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r |-> gpos_r <= gs_r) else $error("gap position past stored groups");
  a_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.clear) |=> (dig_r == 3'd0 && cur_r == '0))
    else $error("open group not reset after push");

endmodule

// ===== tb/ipv6_text_to_bits_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_to_bits_parser_test
// feeds address text one character per transfer: a few hand-picked corner
// strings, then random addresses that are mostly well formed (some damaged)
// mixed with character noise. every accepted character runs through a local
// parser model; each address transfer is checked against the oldest
// predicted address, field by field.
// ----------------------------------------------------------------------------
module ipv6_text_to_bits_parser_test;
  import ip6p_pkg::*;

  localparam int CHAR_TARGET    = 1150;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        malformed;
  } address_t;

  typedef enum logic [2:0] {
    FAULT_REPLACE,
    FAULT_COLON,
    FAULT_DROP,
    FAULT_DIGIT,
    FAULT_EXTRA_GROUP
  } text_fault_t;

  logic clk;
  logic rst_n;

  ip6p_in_if  in_ch ();
  ip6p_out_if out_ch ();

  ipv6_text_to_bits_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // stimulus and expectations
  text_char_t  pending_chars[$];
  address_t    expected_addrs[$];
  logic [7:0]  addr_text[$];
  int          total_chars;
  int          chars_sent;
  int          fail_count;
  int          stall_left;
  bit          stall_done;
  int          idle_cycles;
  address_t    predicted_addr;

  // parser model state
  logic [15:0] grp_row [GROUP_COUNT];
  logic [3:0]  grp_count;
  logic [15:0] digit_acc;
  logic [2:0]  digit_count;
  logic [3:0]  gap_at;
  logic        gap_found;
  logic        after_colon;
  logic        addr_bad;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  task automatic clear_parse();
    for (int k = 0; k < GROUP_COUNT; k++) grp_row[k] = '0;
    grp_count   = '0;
    digit_acc   = '0;
    digit_count = '0;
    gap_at      = '0;
    gap_found   = 1'b0;
    after_colon = 1'b0;
    addr_bad    = 1'b0;
  endtask

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // a ninth group is never stored
  task automatic store_group();
    if (grp_count >= GROUP_COUNT) begin
      addr_bad = 1'b1;
      return;
    end
    grp_row[grp_count[2:0]] = digit_acc;
    grp_count   = grp_count + 4'd1;
    digit_acc   = '0;
    digit_count = '0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int nib;
    if (addr_bad) return;
    if (c == COLON_CHAR) begin
      if (after_colon) begin
        if (gap_found) begin
          addr_bad = 1'b1;
          return;
        end
        gap_found = 1'b1;
        gap_at    = grp_count;
      end else if (digit_count != 0) begin
        store_group();
      end else if (grp_count != 0 || gap_found) begin
        // empty group between colons
        addr_bad = 1'b1;
        return;
      end
      after_colon = 1'b1;
      return;
    end
    nib = nibble_of(c);
    if (nib < 0) begin
      addr_bad = 1'b1;
      return;
    end
    // single colon at the very front
    if (after_colon && grp_count == 0 && !gap_found) begin
      addr_bad = 1'b1;
      return;
    end
    if (digit_count >= MAX_DIGITS) begin
      addr_bad = 1'b1;
      return;
    end
    digit_acc   = {digit_acc[11:0], nib[3:0]};
    digit_count = digit_count + 3'd1;
    after_colon = 1'b0;
  endtask

  task automatic close_address(output address_t res);
    logic        bad;
    int          zeros;
    logic [15:0] g;
    logic [63:0] hi;
    logic [63:0] lo;
    bad = addr_bad;
    hi  = '0;
    lo  = '0;
    if (!bad) begin
      if (digit_count != 0) begin
        store_group();
        bad = addr_bad;
      end else if (!(after_colon && gap_found && gap_at == grp_count)) begin
        // trailing single colon or nothing at all
        bad = 1'b1;
      end
    end
    if (!bad && (gap_found ? (grp_count > GROUP_COUNT - 1) : (grp_count != GROUP_COUNT)))
      bad = 1'b1;
    if (!bad) begin
      zeros = gap_found ? GROUP_COUNT - int'(grp_count) : 0;
      for (int k = 0; k < GROUP_COUNT; k++) begin
        if (!gap_found || k < int'(gap_at)) g = grp_row[k];
        else if (k < int'(gap_at) + zeros) g = '0;
        else g = grp_row[k - zeros];
        if (k < 4) hi = {hi[47:0], g};
        else lo = {lo[47:0], g};
      end
    end
    res.addr_hi   = bad ? 64'd0 : hi;
    res.addr_lo   = bad ? 64'd0 : lo;
    res.malformed = bad;
  endtask

  // ------------------------------------------------------------ stimulus

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endtask

  task automatic flush_text();
    for (int i = 0; i < addr_text.size(); i++) begin
      pending_chars.push_back('{ch: addr_text[i], last: (i == addr_text.size() - 1)});
    end
    addr_text.delete();
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  // mostly random digits, with all-ones and zero groups favored
  task automatic add_group();
    int pick;
    int n;
    pick = $urandom_range(9);
    if (pick == 0) begin
      repeat (4) addr_text.push_back($urandom_range(1) ? "f" : "F");
    end else if (pick == 1) begin
      addr_text.push_back("0");
    end else begin
      n = $urandom_range(1, MAX_DIGITS);
      repeat (n) addr_text.push_back(random_hex_char());
    end
  endtask

  task automatic build_address();
    int n;
    int left;
    if ($urandom_range(1)) begin
      // compressed form, zero to seven explicit groups
      n    = $urandom_range(0, GROUP_COUNT - 1);
      left = $urandom_range(0, n);
      for (int i = 0; i < left; i++) begin
        if (i != 0) addr_text.push_back(COLON_CHAR);
        add_group();
      end
      addr_text.push_back(COLON_CHAR);
      addr_text.push_back(COLON_CHAR);
      for (int i = left; i < n; i++) begin
        if (i != left) addr_text.push_back(COLON_CHAR);
        add_group();
      end
    end else begin
      for (int i = 0; i < GROUP_COUNT; i++) begin
        if (i != 0) addr_text.push_back(COLON_CHAR);
        add_group();
      end
    end
  endtask

  task automatic damage_address();
    text_fault_t fault;
    int          pos;
    fault = text_fault_t'($urandom_range(4));
    pos   = $urandom_range(addr_text.size() - 1);
    case (fault)
      FAULT_REPLACE:     addr_text[pos] = 8'($urandom_range(255));
      FAULT_COLON:       addr_text.insert(pos, COLON_CHAR);
      FAULT_DROP: begin
        if (addr_text.size() > 1) addr_text.delete(pos);
      end
      FAULT_DIGIT:       addr_text.insert(pos, random_hex_char());
      FAULT_EXTRA_GROUP: begin
        addr_text.push_back(COLON_CHAR);
        add_group();
      end
      default: ;
    endcase
  endtask

  task automatic build_noise();
    int n;
    int pick;
    n = $urandom_range(1, 6);
    repeat (n) begin
      pick = $urandom_range(9);
      if (pick < 4) addr_text.push_back(COLON_CHAR);
      else if (pick < 7) addr_text.push_back(random_hex_char());
      else addr_text.push_back(8'($urandom_range(255)));
    end
  endtask

  function automatic int send_gap_pct();
    if (chars_sent < total_chars / 3) return 8;
    if (chars_sent < 2 * total_chars / 3) return 62;
    return 0;
  endfunction

  function automatic int recv_gap_pct();
    if (chars_sent < total_chars / 3) return 62;
    if (chars_sent < 2 * total_chars / 3) return 8;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------- driver side

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.character <= 8'd0;
      in_ch.last_char <= 1'b0;
    end else begin
      // model follows every accepted character
      if (in_ch.valid && in_ch.ready) begin
        absorb_char(in_ch.character);
        if (in_ch.last_char) begin
          close_address(predicted_addr);
          expected_addrs.push_back(predicted_addr);
          clear_parse();
        end
        chars_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
          in_ch.valid     <= 1'b1;
          in_ch.character <= pending_chars[0].ch;
          in_ch.last_char <= pending_chars[0].last;
          pending_chars.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------- monitor side

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_addrs.size() == 0) begin
          $display("%0t: address transfer with nothing expected, actual %h %h %b",
                   $realtime, out_ch.address_high, out_ch.address_low, out_ch.malformed);
          fail_count++;
        end else begin
          check_field("address_high", expected_addrs[0].addr_hi, out_ch.address_high);
          check_field("address_low", expected_addrs[0].addr_lo, out_ch.address_low);
          check_field("malformed", 64'(expected_addrs[0].malformed),
                      64'(out_ch.malformed));
          expected_addrs.pop_front();
        end
      end
      // one long hold-off while characters keep coming
      if (!stall_done && chars_sent >= 2 * total_chars / 3 + 40) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_gap_pct());
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ------------------------------------------------------------ sequence

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.character = 8'd0;
    in_ch.last_char = 1'b0;
    out_ch.ready    = 1'b0;
    chars_sent      = 0;
    fail_count      = 0;
    stall_left      = 0;
    stall_done      = 1'b0;
    idle_cycles     = 0;
    clear_parse();

    // corner strings: gap alone, trailing and leading gap, single colons,
    // triple colon, long group, bad character, too few groups
    queue_text("::");
    queue_text("1::");
    queue_text("::F");
    queue_text(":a");
    queue_text("a:");
    queue_text(":::");
    queue_text("12345");
    queue_text("g");
    queue_text("0");

    // random addresses, some damaged, and short bursts of noise
    while (pending_chars.size() < CHAR_TARGET) begin
      if ($urandom_range(99) < 85) begin
        build_address();
        if ($urandom_range(99) < 30) damage_address();
      end else begin
        build_noise();
      end
      flush_text();
    end
    total_chars = pending_chars.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_sent < total_chars || expected_addrs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ip6p_pkg.sv
design/ip6p_in_if.sv
design/ip6p_out_if.sv
design/ip6p_cell.sv
design/ip6p_ctrl.sv
design/ipv6_text_to_bits_parser.sv
tb/ipv6_text_to_bits_parser_test.sv
